@@ src/dres_pkg.sv @@
// shared types, sizes and codes of the dependency/resource event scheduler
package dres_pkg;

  localparam int MAX_EVENTS  = 1024;
  localparam int NUM_DEVICES = 16;
  localparam int MAX_DEPS    = 4;
  localparam int TIME_BITS   = 48;

  // fixed field widths of the stream items
  localparam int DEV_W     = 5;
  localparam int DUR_W     = 32;
  localparam int NDEP_W    = 3;
  localparam int DEP_W     = 10;
  localparam int STAT_W    = 2;
  localparam int IDX_W     = 10;
  localparam int OUT_TW    = 48;
  localparam int DEP_FIELDS = 4;
  localparam int DEPSEL_W  = 2;

  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 112;

  localparam int DEP_LIMIT = (MAX_DEPS < DEP_FIELDS) ? MAX_DEPS : DEP_FIELDS;
  localparam int EV_AW     = $clog2(MAX_EVENTS);
  localparam int CNT_W     = $clog2(MAX_EVENTS + 1);
  localparam int CMP_W     = (CNT_W > DEP_W) ? CNT_W : DEP_W;
  localparam int RES_W     = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int SUM_W     = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;
  localparam int NUM_DEV_CODES = 16;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [RES_W-1:0]     res_idx_t;
  typedef res_idx_t             res_map_t [NUM_DEV_CODES];

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_DEP = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_MAX,
    S_ADD,
    S_COMMIT,
    S_DONE
  } state_t;

  // device code to resource slot, folded at elaboration
  function automatic res_map_t build_res_map();
    res_map_t m;
    for (int i = 0; i < NUM_DEV_CODES; i++) begin
      m[i] = res_idx_t'(i % NUM_DEVICES);
    end
    return m;
  endfunction

  localparam res_map_t RES_MAP = build_res_map();

endpackage

@@ src/dependency_resource_event_scheduler_core.sv @@
// top level: event scheduler with dependency and resource constraints
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------------
//  in_     | in  | in_tvalid / in_tready | tdata: device, duration, deps; tuser
//  out_    | out | out_tvalid/out_tready | tdata: index, start, end; tuser: status
//  cfg_    | in  | cfg_tvalid/cfg_tready | tdata: pipelined_mode
//
// a request steps from accept to check, then a read and a compare step per
// dependency (none if it joins the scan group), then add, commit, result load;
// the single end-table read port and shared compare unit take them in turn
// a rejected request goes from accept and check straight to result load
// rst_n is synchronous, active low; it clears control, free times, event count
// and the scan group; the end table is not cleared and needs no sweep
// a result waits in the output register; the sequencer holds in its last step
// until that register is free, and in_tready is high only in the idle step;
// cfg_tready is high only in the idle step with no request offered
module dependency_resource_event_scheduler_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // device_id[4:0], duration_ticks[36:5], dep_count[39:37],
  // dep_a[49:40], dep_b[59:50], dep_c[69:60], dep_d[79:70]
  input  logic [dres_pkg::IN_TDATA_W-1:0]   in_tdata,
  // pool_scan_flag[0], batch_break[1]
  input  logic [dres_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // event_index[9:0], start_time[57:10], end_time[105:58], zero fill above
  output logic [dres_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status[1:0]
  output logic [dres_pkg::STAT_W-1:0]       out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pipelined_mode[0]
  input  logic                              cfg_tdata,
  input  logic                              cfg_tvalid,
  output logic                              cfg_tready
);

  // sequencer
  dres_pkg::state_t state_r, state_nxt;

  // request registers
  logic signed [dres_pkg::DEV_W-1:0]  dev_r;
  logic [dres_pkg::DUR_W-1:0]         dur_r;
  logic                               pool_r;
  logic                               brk_r;
  logic [dres_pkg::NDEP_W-1:0]        nd_r;
  logic [dres_pkg::DEP_W-1:0]         deps_r [dres_pkg::DEP_FIELDS];
  logic [dres_pkg::DEPSEL_W-1:0]      dep_i_r;

  // working registers
  dres_pkg::time_t                    start_r;
  dres_pkg::time_t                    end_r;
  dres_pkg::status_t                  status_r;
  logic [dres_pkg::IDX_W-1:0]         idx_r;
  logic                               joins_r;
  logic                               rsv_en_r;
  dres_pkg::res_idx_t                 res_r;
  dres_pkg::time_t                    rd_data_r;

  // scheduler state
  dres_pkg::time_t                    rft_r [dres_pkg::NUM_DEVICES];
  logic [dres_pkg::CNT_W-1:0]         event_count_r;
  logic                               pipe_r;
  logic                               grp_open_r;
  dres_pkg::time_t                    grp_start_r;
  logic signed [dres_pkg::DEV_W-1:0]  grp_dev_r;
  logic [dres_pkg::NDEP_W-1:0]        grp_cnt_r;
  logic [dres_pkg::DEP_W-1:0]         grp_deps_r [dres_pkg::DEP_LIMIT];

  // end time of every committed event
  dres_pkg::time_t                    end_table [dres_pkg::MAX_EVENTS];

  // output register
  logic                               out_valid_r;
  dres_pkg::status_t                  out_stat_r;
  logic [dres_pkg::IDX_W-1:0]         out_idx_r;
  logic [dres_pkg::OUT_TW-1:0]        out_start_r;
  logic [dres_pkg::OUT_TW-1:0]        out_end_r;

  // handshakes
  logic in_fire, cfg_fire, out_load;

  // check-step logic
  logic                               chk_full;
  logic                               chk_bad;
  logic                               chk_join;
  dres_pkg::res_idx_t                 chk_res;
  logic [dres_pkg::NDEP_W:0]          dep_next;
  logic                               more_deps;
  logic [dres_pkg::SUM_W-1:0]         sum;
  dres_pkg::time_t                    sat_end;

  assign in_fire  = in_tvalid && in_tready;
  assign cfg_fire = cfg_tvalid && cfg_tready;
  assign out_load = (state_r == dres_pkg::S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    chk_full = (event_count_r == dres_pkg::CNT_W'(dres_pkg::MAX_EVENTS));
    chk_bad  = (nd_r > dres_pkg::NDEP_W'(dres_pkg::DEP_LIMIT));
    // any listed dependency that is not an earlier event
    for (int i = 0; i < dres_pkg::DEP_FIELDS; i++) begin
      if ((dres_pkg::NDEP_W'(i) < nd_r) &&
          (dres_pkg::CMP_W'(deps_r[i]) >= dres_pkg::CMP_W'(event_count_r))) begin
        chk_bad = 1'b1;
      end
    end
    // scan group membership: serial mode, pool flag, no break, open group, same dependency list
    chk_join = !pipe_r && pool_r && !brk_r && grp_open_r && (nd_r == grp_cnt_r);
    for (int i = 0; i < dres_pkg::DEP_LIMIT; i++) begin
      if ((dres_pkg::NDEP_W'(i) < nd_r) && (grp_deps_r[i] != deps_r[i])) begin
        chk_join = 1'b0;
      end
    end
    // a join only happens in serial mode, so slot zero serves both cases
    chk_res = pipe_r ? dres_pkg::RES_MAP[dev_r[dres_pkg::DEV_W-2:0]] : '0;
  end

  assign dep_next  = {1'b0, dep_i_r} + (dres_pkg::NDEP_W+1)'(1);
  assign more_deps = (dep_next < {1'b0, nd_r});

  // saturating adder for the end time
  assign sum     = dres_pkg::SUM_W'(start_r) + dres_pkg::SUM_W'(dur_r);
  assign sat_end = (sum > dres_pkg::SUM_W'(dres_pkg::TIME_MAX)) ? dres_pkg::TIME_MAX
                                                               : dres_pkg::time_t'(sum);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dres_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = dres_pkg::S_CHECK;
        end
      end
      dres_pkg::S_CHECK: begin
        if (chk_full || chk_bad) begin
          state_nxt = dres_pkg::S_DONE;
        end else if (chk_join || (nd_r == '0)) begin
          state_nxt = dres_pkg::S_ADD;
        end else begin
          state_nxt = dres_pkg::S_READ;
        end
      end
      dres_pkg::S_READ:   state_nxt = dres_pkg::S_MAX;
      dres_pkg::S_MAX: begin
        state_nxt = more_deps ? dres_pkg::S_READ : dres_pkg::S_ADD;
      end
      dres_pkg::S_ADD:    state_nxt = dres_pkg::S_COMMIT;
      dres_pkg::S_COMMIT: state_nxt = dres_pkg::S_DONE;
      dres_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = dres_pkg::S_IDLE;
        end
      end
      default:            state_nxt = dres_pkg::S_IDLE;
    endcase
  end

  // handshake outputs; a mode write never lands while a request is in flight
  always_comb begin
    in_tready  = (state_r == dres_pkg::S_IDLE);
    cfg_tready = (state_r == dres_pkg::S_IDLE) && !in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dres_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture and working datapath
  always_ff @(posedge clk) begin
    case (state_r)
      dres_pkg::S_IDLE: begin
        if (in_fire) begin
          dev_r  <= in_tdata[4:0];
          // dependency-only events carry no duration
          dur_r  <= in_tdata[4] ? '0 : in_tdata[36:5];
          nd_r   <= in_tdata[39:37];
          deps_r[0] <= in_tdata[49:40];
          deps_r[1] <= in_tdata[59:50];
          deps_r[2] <= in_tdata[69:60];
          deps_r[3] <= in_tdata[79:70];
          pool_r <= in_tuser[0];
          brk_r  <= in_tuser[1];
        end
      end
      dres_pkg::S_CHECK: begin
        dep_i_r  <= '0;
        joins_r  <= chk_join;
        res_r    <= chk_res;
        rsv_en_r <= chk_join ? !grp_dev_r[dres_pkg::DEV_W-1] : !dev_r[dres_pkg::DEV_W-1];
        idx_r    <= '0;
        end_r    <= '0;
        if (chk_full) begin
          status_r <= dres_pkg::ST_FULL;
          start_r  <= '0;
        end else if (chk_bad) begin
          status_r <= dres_pkg::ST_BAD_DEP;
          start_r  <= '0;
        end else begin
          status_r <= dres_pkg::ST_OK;
          if (chk_join) begin
            start_r <= grp_start_r;
          end else if (dev_r[dres_pkg::DEV_W-1]) begin
            start_r <= '0;
          end else begin
            start_r <= rft_r[chk_res];
          end
        end
      end
      dres_pkg::S_MAX: begin
        // shared compare: keep the latest dependency end
        if (rd_data_r > start_r) begin
          start_r <= rd_data_r;
        end
        dep_i_r <= dep_next[dres_pkg::DEPSEL_W-1:0];
      end
      dres_pkg::S_ADD: begin
        end_r <= sat_end;
      end
      dres_pkg::S_COMMIT: begin
        idx_r <= dres_pkg::IDX_W'(event_count_r);
      end
      default: begin
      end
    endcase
  end

  // end table: one write, one registered read
  always_ff @(posedge clk) begin
    if (state_r == dres_pkg::S_COMMIT) begin
      end_table[event_count_r[dres_pkg::EV_AW-1:0]] <= end_r;
    end
    rd_data_r <= end_table[dres_pkg::EV_AW'(deps_r[dep_i_r])];
  end

  // scheduler state: free times, count, scan group, mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dres_pkg::NUM_DEVICES; i++) begin
        rft_r[i] <= '0;
      end
      event_count_r <= '0;
      pipe_r        <= 1'b0;
      grp_open_r    <= 1'b0;
      grp_start_r   <= '0;
      grp_dev_r     <= '0;
      grp_cnt_r     <= '0;
      for (int i = 0; i < dres_pkg::DEP_LIMIT; i++) begin
        grp_deps_r[i] <= '0;
      end
    end else begin
      if (state_r == dres_pkg::S_COMMIT) begin
        event_count_r <= event_count_r + dres_pkg::CNT_W'(1);
        // a group lane only pushes the reservation further out
        if (rsv_en_r && (!joins_r || (end_r > rft_r[res_r]))) begin
          rft_r[res_r] <= end_r;
        end
        if (!joins_r) begin
          grp_open_r <= !pipe_r && pool_r;
          if (!pipe_r && pool_r) begin
            grp_start_r <= start_r;
            grp_dev_r   <= dev_r;
            grp_cnt_r   <= nd_r;
            for (int i = 0; i < dres_pkg::DEP_LIMIT; i++) begin
              grp_deps_r[i] <= (dres_pkg::NDEP_W'(i) < nd_r) ? deps_r[i] : '0;
            end
          end
        end
      end
      // mode change closes any open scan group
      if (cfg_fire) begin
        pipe_r     <= cfg_tdata;
        grp_open_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_stat_r  <= status_r;
      out_idx_r   <= idx_r;
      out_start_r <= dres_pkg::OUT_TW'(start_r);
      out_end_r   <= dres_pkg::OUT_TW'(end_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {6'd0, out_end_r, out_start_r, out_idx_r};

  // each committed event takes exactly one new index
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dres_pkg::S_COMMIT) |=>
      (event_count_r == $past(event_count_r) + dres_pkg::CNT_W'(1)))
    else $error("event count did not advance by one on commit");

  // the index space is never overrun
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (event_count_r <= dres_pkg::CNT_W'(dres_pkg::MAX_EVENTS)))
    else $error("event count beyond table depth");

  // a scheduled event never ends before it starts
  a_end_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r == dres_pkg::ST_OK)) |-> (out_end_r >= out_start_r))
    else $error("scheduled end earlier than start");

  // rejected requests report zero times and index
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r != dres_pkg::ST_OK)) |->
      ((out_end_r == '0) && (out_start_r == '0) && (out_idx_r == '0)))
    else $error("rejected request carries nonzero result fields");

endmodule
